>>> hw/rtl/accel_force_and_tilt_alarm_macros.svh
// Assertion macros for the force and tilt alarm block.
// Taken in by the top level; needs clk_i and rst_ni in scope.
`ifndef ACCEL_FORCE_AND_TILT_ALARM_MACROS_SVH
`define ACCEL_FORCE_AND_TILT_ALARM_MACROS_SVH

// Checked at every edge once reset has been released.
`define AFT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, during reset too.
`define AFT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hw/rtl/aft_pkg.sv
// Package for the force and tilt alarm block: payload types, cell types,
// the arctangent table and the square-root step. No dependencies.
`timescale 1ns / 1ps

package aft_pkg;

  localparam int CordicStepsDef = 16;
  localparam int TableLen       = 24;
  localparam int RootW          = 24;
  localparam int RadW           = 2 * RootW;
  localparam int RemW           = RootW + 2;
  localparam int CordW          = 27;
  localparam int AccW           = 32;
  localparam int TiltMax        = 9000;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_FORCE_LIMIT = 1'b0,
    REG_TILT_LIMIT  = 1'b1
  } reg_idx_e;

  // Face orientation codes; the unused code acts as other.
  localparam logic [1:0] FaceOther = 2'd0;
  localparam logic [1:0] FaceUp    = 2'd1;
  localparam logic [1:0] FaceDown  = 2'd2;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [1:0]         face_code;
  } in_req_t;

  typedef struct packed {
    logic [15:0] force_magnitude;
    logic [13:0] tilt_angle;
    logic        stress_alarm;
    logic        tilt_alarm;
  } out_req_t;

  // One digit-by-digit square root in flight.
  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } root_t;

  // Square-root cell payload: planar and total roots side by side.
  typedef struct packed {
    root_t              p;
    root_t              t;
    logic [1:0]         face;
    logic signed [15:0] z;
  } sqrt_t;

  // CORDIC cell payload.
  typedef struct packed {
    logic signed [CordW-1:0] cx;
    logic signed [CordW-1:0] cy;
    logic signed [AccW-1:0]  acc;
    logic [1:0]              face;
    logic                    zero_p;
    logic                    z_pos;
    logic [RootW-1:0]        mag_root;
    logic                    rem_nz;
  } cordic_t;

  // atan(2^-i) in 0.01 degree scaled by 2^16, rounded.
  function automatic logic signed [AccW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [AccW-1:0] v;
    v = '0;
    case (idx)
      5'd0:  v = 32'sd294912000;
      5'd1:  v = 32'sd174096719;
      5'd2:  v = 32'sd91987925;
      5'd3:  v = 32'sd46694507;
      5'd4:  v = 32'sd23437865;
      5'd5:  v = 32'sd11730358;
      5'd6:  v = 32'sd5866610;
      5'd7:  v = 32'sd2933484;
      5'd8:  v = 32'sd1466764;
      5'd9:  v = 32'sd733385;
      5'd10: v = 32'sd366693;
      5'd11: v = 32'sd183346;
      5'd12: v = 32'sd91673;
      5'd13: v = 32'sd45837;
      5'd14: v = 32'sd22918;
      5'd15: v = 32'sd11459;
      5'd16: v = 32'sd5730;
      5'd17: v = 32'sd2865;
      5'd18: v = 32'sd1432;
      5'd19: v = 32'sd716;
      5'd20: v = 32'sd358;
      5'd21: v = 32'sd179;
      5'd22: v = 32'sd90;
      5'd23: v = 32'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

  // One result bit of a restoring square root.
  function automatic root_t sqrt_step(input root_t s);
    root_t             r;
    logic [RemW+1:0]   cur;
    logic [RemW+1:0]   trial;
    cur   = {s.rem, s.rad[RadW-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    r.rad = {s.rad[RadW-3:0], 2'b00};
    if (cur >= trial) begin
      r.rem  = RemW'(cur - trial);
      r.root = {s.root[RootW-2:0], 1'b1};
    end else begin
      r.rem  = cur[RemW-1:0];
      r.root = {s.root[RootW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/aft_sqrt_cell.sv
// One cell of the square-root chain: resolves one bit of both roots.
// Depends on aft_pkg.
`timescale 1ns / 1ps

module aft_sqrt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          ce_i,
  input  logic          valid_i,
  input  aft_pkg::sqrt_t data_i,
  output logic          valid_o,
  output aft_pkg::sqrt_t data_o
);
  import aft_pkg::*;

  logic  valid_q;
  sqrt_t data_d, data_q;

  // Both roots take their next digit.
  always_comb begin
    data_d   = data_i;
    data_d.p = sqrt_step(data_i.p);
    data_d.t = sqrt_step(data_i.t);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ce_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hw/rtl/aft_cordic_cell.sv
// One vectoring CORDIC iteration with its own shift and table angle.
// Depends on aft_pkg.
`timescale 1ns / 1ps

module aft_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            ce_i,
  input  logic            valid_i,
  input  aft_pkg::cordic_t data_i,
  output logic            valid_o,
  output aft_pkg::cordic_t data_o
);
  import aft_pkg::*;

  localparam logic signed [AccW-1:0] Angle = atan_entry(5'(STEP));

  logic    valid_q;
  cordic_t data_d, data_q;
  logic signed [CordW-1:0] dx, dy;

  // Rotate towards the x axis; shifts are arithmetic, so they floor.
  always_comb begin
    dx     = data_i.cy >>> STEP;
    dy     = data_i.cx >>> STEP;
    data_d = data_i;
    if (!data_i.cy[CordW-1]) begin
      data_d.cx  = data_i.cx + dx;
      data_d.cy  = data_i.cy - dy;
      data_d.acc = data_i.acc + Angle;
    end else begin
      data_d.cx  = data_i.cx - dx;
      data_d.cy  = data_i.cy + dy;
      data_d.acc = data_i.acc - Angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ce_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hw/rtl/accel_force_and_tilt_alarm.sv
// Top level of the force and tilt alarm block: input squares, square-root
// and CORDIC cell chains, result stage and output skid. Uses aft_pkg and cells.
`timescale 1ns / 1ps
`include "accel_force_and_tilt_alarm_macros.svh"

// Usage
// The input channel (in_valid_i, in_stall_o, in_data_i) takes one sample
// request per cycle while in_stall_o is low: x, y, z acceleration and the
// face code. The output channel (out_valid_o, out_stall_i, out_data_o)
// returns exactly one result request per sample, in order: magnitude, tilt
// and the two alarms. The path holds these register stages: one of squares,
// one of sums, 24 square-root cells, one CORDIC cell per step (CORDIC_STEPS,
// capped at TableLen) and the output register. Throughput is one sample per
// cycle while in_stall_o is low; each cell of both chains holds one sample
// and hands it on whenever the chain advances. The user writes the limits
// over the APB port (force_limit at 0, tilt_limit at 4) only while no sample
// is in flight; the block does not enforce this. Reset clears both limits
// and all valid bits. When the receiver stalls, the finished result holds
// on the output and the next one drops into a skid register; only while
// that register is full does in_stall_o rise and the whole chain hold still.
module accel_force_and_tilt_alarm #(
  parameter int CORDIC_STEPS = aft_pkg::CordicStepsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  aft_pkg::in_req_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output aft_pkg::out_req_t out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import aft_pkg::*;

  localparam int NumSteps = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;

  // Configuration registers.
  logic [15:0] force_limit_q;
  logic [13:0] tilt_limit_q;
  reg_idx_e    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_limit_q <= '0;
      tilt_limit_q  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_FORCE_LIMIT: force_limit_q <= pwdata[15:0];
        REG_TILT_LIMIT:  tilt_limit_q  <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FORCE_LIMIT: prdata = {16'd0, force_limit_q};
      REG_TILT_LIMIT:  prdata = {18'd0, tilt_limit_q};
      default:         prdata = '0;
    endcase
  end

  // The chain advances whenever the skid register is empty.
  logic ce;
  logic skid_valid_q;
  assign ce         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // Squares of the three axes.
  logic               sq_valid_q;
  logic [30:0]        sq_x_q, sq_y_q, sq_z_q;
  logic [1:0]         sq_face_q;
  logic signed [15:0] sq_z_val_q;
  logic signed [31:0] px, py, pz;

  assign px = in_data_i.accel_x * in_data_i.accel_x;
  assign py = in_data_i.accel_y * in_data_i.accel_y;
  assign pz = in_data_i.accel_z * in_data_i.accel_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
    end else if (ce) begin
      sq_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      sq_x_q     <= px[30:0];
      sq_y_q     <= py[30:0];
      sq_z_q     <= pz[30:0];
      sq_face_q  <= in_data_i.face_code;
      sq_z_val_q <= in_data_i.accel_z;
    end
  end

  // Planar and total sums, loaded as radicands of the root chain.
  logic        sum_valid_q;
  sqrt_t       sum_q, sum_d;
  logic [31:0] planar, total;

  assign planar = {1'b0, sq_x_q} + {1'b0, sq_y_q};
  assign total  = planar + {1'b0, sq_z_q};

  always_comb begin
    sum_d.p.rad  = {planar, 16'd0};
    sum_d.p.rem  = '0;
    sum_d.p.root = '0;
    sum_d.t.rad  = {16'd0, total};
    sum_d.t.rem  = '0;
    sum_d.t.root = '0;
    sum_d.face   = sq_face_q;
    sum_d.z      = sq_z_val_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (ce) begin
      sum_valid_q <= sq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      sum_q <= sum_d;
    end
  end

  // Square-root chain: one result bit per cell.
  logic  sqv [RootW+1];
  sqrt_t sqd [RootW+1];

  assign sqv[0] = sum_valid_q;
  assign sqd[0] = sum_q;

  for (genvar g = 0; g < RootW; g++) begin : g_sqrt
    aft_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ce_i    (ce),
      .valid_i (sqv[g]),
      .data_i  (sqd[g]),
      .valid_o (sqv[g+1]),
      .data_o  (sqd[g+1])
    );
  end

  // CORDIC chain, seeded with the planar radius and the scaled z axis.
  logic    cov [NumSteps+1];
  cordic_t cod [NumSteps+1];
  sqrt_t   root_end;

  assign root_end = sqd[RootW];
  assign cov[0]   = sqv[RootW];

  always_comb begin
    cod[0].cx       = CordW'({1'b0, root_end.p.root});
    cod[0].cy       = {{(CordW-24){root_end.z[15]}}, root_end.z, 8'd0};
    cod[0].acc      = '0;
    cod[0].face     = root_end.face;
    cod[0].zero_p   = (root_end.p.root == '0);
    cod[0].z_pos    = !root_end.z[15] && (root_end.z != '0);
    cod[0].mag_root = root_end.t.root;
    cod[0].rem_nz   = (root_end.t.rem != '0);
  end

  for (genvar g = 0; g < NumSteps; g++) begin : g_cordic
    aft_cordic_cell #(
      .STEP (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ce_i    (ce),
      .valid_i (cov[g]),
      .data_i  (cod[g]),
      .valid_o (cov[g+1]),
      .data_o  (cod[g+1])
    );
  end

  // Result: round, clamp, apply face offset, fold, take magnitude, set alarms.
  cordic_t            fin;
  out_req_t           res;
  logic signed [31:0] rnd;
  logic signed [31:0] rnd_sh;
  logic signed [15:0] h;
  logic signed [15:0] ang;
  logic [15:0]        abs_ang;

  assign fin = cod[NumSteps];

  always_comb begin
    rnd    = fin.acc + 32'sd32768;
    rnd_sh = rnd >>> 16;
    h      = rnd_sh[15:0];
    if (h > 16'sd9000) begin
      h = 16'sd9000;
    end
    if (h < -16'sd9000) begin
      h = -16'sd9000;
    end
    // Zero planar part: straight up or down.
    if (fin.zero_p) begin
      h = fin.z_pos ? 16'sd9000 : -16'sd9000;
    end
    ang = h;
    if (fin.face == FaceUp) begin
      ang = h - 16'sd9000;
    end else if (fin.face == FaceDown) begin
      ang = h + 16'sd9000;
    end
    if (ang > 16'sd9000) begin
      ang = ang - 16'sd9000;
    end else if (ang < -16'sd9000) begin
      ang = ang + 16'sd9000;
    end
    abs_ang = ang[15] ? 16'(-ang) : 16'(ang);

    res.force_magnitude = (fin.mag_root[RootW-1:16] != '0) ? 16'hFFFF :
                          fin.mag_root[15:0];
    res.tilt_angle      = abs_ang[13:0];
    // Exact magnitude above the limit: root above it, or equal with a remainder.
    res.stress_alarm    = (force_limit_q != '0) &&
                          ((fin.mag_root > RootW'(force_limit_q)) ||
                           ((fin.mag_root == RootW'(force_limit_q)) && fin.rem_nz));
    res.tilt_alarm      = (tilt_limit_q != '0) && (abs_ang[13:0] > tilt_limit_q);
  end

  // Output register with a skid slot behind it.
  logic     out_valid_q;
  out_req_t out_q, skid_q;
  logic     load_out;
  logic     fin_take;

  assign load_out = !out_valid_q || !out_stall_i;
  assign fin_take = cov[NumSteps] && !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q  <= skid_valid_q || fin_take;
      skid_valid_q <= 1'b0;
    end else if (fin_take) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (fin_take) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks on the skid stage and the result fields.
  `AFT_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid full with output empty")
  `AFT_ASSERT(a_skid_on_stall, $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i),
              "skid filled without a stalled output")
  `AFT_ASSERT(a_tilt_range, out_valid_o |-> (out_data_o.tilt_angle <= 14'd9000),
              "tilt out of range")
  `AFT_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

endmodule
